// File: src/ffa_pkg.sv
// Shared types and constants for the first-fit block allocator.
`default_nettype none
package ffa_pkg;

	localparam int SIZE_W = 13;
	localparam int OFFS_W = 12;
	localparam int HDR_W  = 14;
	localparam int FREE_BIT = 13;
	localparam int POS_W  = 15;
	localparam int ADDR_W = 16;

	localparam logic [1:0] REQ_INIT  = 2'd0;
	localparam logic [1:0] REQ_ALLOC = 2'd1;
	localparam logic [1:0] REQ_FREE  = 2'd2;
	localparam logic [1:0] REQ_DONE  = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_A_RD,
		ST_A_CHK,
		ST_A_MARK,
		ST_F_RD,
		ST_F_CHK,
		ST_F_PREV,
		ST_F_NXT,
		ST_F_NCHK,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [HDR_W-1:0]  wdata;
	} ram_req_t;

endpackage
`default_nettype wire

// File: src/ffa_hdr_ram.sv
// Single-port header memory with registered read data.
`default_nettype none
module ffa_hdr_ram #(
	parameter int DEPTH = 4096
) (
	input  logic                    clk,
	input  ffa_pkg::ram_req_t       req,
	output logic [ffa_pkg::HDR_W-1:0] rdata
);
	import ffa_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic [HDR_W-1:0] mem [DEPTH];
	logic [HDR_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr[AW-1:0]] <= req.wdata;
		end
		rdata_q <= mem[req.addr[AW-1:0]];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// File: src/first_fit_block_allocator.sv
// Top level of the first-fit block allocator with a header-walking sequencer.
// Init and done go from idle straight to the response state.
// Allocate reads and checks each block header in turn, then marks the fitting block (split first if large).
// Free reads and checks each header up to the target, then merges with free neighbour blocks.
// One request at a time; the single-port header memory sets the walk rate.
// Reset clears the sequencer, pool state and output valid; headers are not cleared.
`default_nettype none
module first_fit_block_allocator #(
	parameter int POOL_BYTES   = 4096,
	parameter int HEADER_BYTES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // req_size[12:0], req_offset[24:13], zero pad
	input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // alloc_offset[11:0], zero pad
	output logic [0:0]  m_axis_tuser   // status[0]
);
	import ffa_pkg::*;

	localparam logic [POS_W-1:0]  HDR_P  = POS_W'(HEADER_BYTES);
	localparam logic [SIZE_W-1:0] HDR_S  = SIZE_W'(HEADER_BYTES);
	localparam logic [31:0]       POOL_L = 32'(POOL_BYTES);
	localparam logic [31:0]       HDR_L  = 32'(HEADER_BYTES);

	state_t state_q, state_d;
	ram_req_t ram_req;
	logic [HDR_W-1:0] rdata;

	logic              pool_active_q;
	logic [SIZE_W-1:0] pool_limit_q;
	logic              out_valid_q;
	logic              out_status_q;
	logic [OFFS_W-1:0] out_offs_q;

	logic [1:0]        req_type_q;
	logic [SIZE_W-1:0] req_size_q;
	logic [OFFS_W-1:0] req_offs_q;
	logic              res_fail_q;
	logic [OFFS_W-1:0] res_offs_q;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  prev_q;
	logic [SIZE_W-1:0] prev_size_q;
	logic              prev_free_q;
	logic              have_prev_q;
	logic [SIZE_W-1:0] cur_size_q;

	logic [1:0]        s_type;
	logic [SIZE_W-1:0] s_size;
	logic [OFFS_W-1:0] s_offs;
	logic              in_acc;
	logic              out_load;
	logic              init_ok;
	logic [SIZE_W-1:0] bsize;
	logic              hfree;
	logic              pos_in;
	logic [POS_W-1:0]  nxt_blk;
	logic              fit;
	logic [SIZE_W-1:0] diff;
	logic              split;
	logic [POS_W-1:0]  split_pos;
	logic              split_in;
	logic [POS_W-1:0]  payload;
	logic [POS_W-1:0]  target;
	logic [SIZE_W-1:0] merge_prev;
	logic [SIZE_W-1:0] merge_next;
	logic [POS_W-1:0]  nxt_cur;

	ffa_hdr_ram #(
		.DEPTH(POOL_BYTES)
	) u_ram (
		.clk  (clk),
		.req  (ram_req),
		.rdata(rdata)
	);

	assign s_type = s_axis_tuser;
	assign s_size = s_axis_tdata[12:0];
	assign s_offs = s_axis_tdata[24:13];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_load      = (state_q == ST_RESP) && (!out_valid_q || m_axis_tready);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0, out_offs_q};
	assign m_axis_tuser  = out_status_q;

	assign init_ok = !pool_active_q && (32'(s_size) >= HDR_L) && (32'(s_size) <= POOL_L);

	assign bsize      = rdata[SIZE_W-1:0];
	assign hfree      = rdata[FREE_BIT];
	assign pos_in     = pos_q < POS_W'(pool_limit_q);
	assign nxt_blk    = pos_q + HDR_P + POS_W'(bsize);
	assign fit        = hfree && (bsize >= req_size_q);
	assign diff       = bsize - req_size_q;
	assign split      = diff > HDR_S;
	assign split_pos  = pos_q + HDR_P + POS_W'(req_size_q);
	assign split_in   = 32'(split_pos) < POOL_L;
	assign payload    = pos_q + HDR_P;
	assign target     = POS_W'(req_offs_q);
	assign merge_prev = prev_size_q + HDR_S + cur_size_q;
	assign merge_next = cur_size_q + HDR_S + bsize;
	assign nxt_cur    = pos_q + HDR_P + POS_W'(cur_size_q);

	always_comb begin
		state_d = state_q;
		ram_req = '0;
		ram_req.addr = ADDR_W'(pos_q);
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					unique case (s_type)
						REQ_INIT: begin
							if (init_ok) begin
								ram_req.we    = 1'b1;
								ram_req.addr  = '0;
								ram_req.wdata = {1'b1, s_size - HDR_S};
							end
							state_d = ST_RESP;
						end
						REQ_ALLOC: state_d = (pool_active_q && s_size != '0) ? ST_A_RD : ST_RESP;
						REQ_FREE:  state_d = pool_active_q ? ST_F_RD : ST_RESP;
						default:   state_d = ST_RESP;
					endcase
				end
			end
			ST_A_RD: state_d = pos_in ? ST_A_CHK : ST_RESP;
			ST_A_CHK: begin
				if (fit) begin
					if (split) begin
						ram_req.we    = split_in;
						ram_req.addr  = ADDR_W'(split_pos);
						ram_req.wdata = {1'b1, diff - HDR_S};
						state_d = ST_A_MARK;
					end else begin
						ram_req.we    = 1'b1;
						ram_req.wdata = {1'b0, bsize};
						state_d = ST_RESP;
					end
				end else begin
					state_d = ST_A_RD;
				end
			end
			ST_A_MARK: begin
				ram_req.we    = 1'b1;
				ram_req.wdata = {1'b0, req_size_q};
				state_d = ST_RESP;
			end
			ST_F_RD: state_d = pos_in ? ST_F_CHK : ST_RESP;
			ST_F_CHK: begin
				priority if (target > payload) begin
					state_d = ST_F_RD;
				end else if (target == payload && !hfree) begin
					ram_req.we    = 1'b1;
					ram_req.wdata = {1'b1, bsize};
					state_d = (have_prev_q && prev_free_q) ? ST_F_PREV : ST_F_NXT;
				end else begin
					state_d = ST_RESP;
				end
			end
			ST_F_PREV: begin
				ram_req.we    = 1'b1;
				ram_req.addr  = ADDR_W'(prev_q);
				ram_req.wdata = {1'b1, merge_prev};
				state_d = ST_F_NXT;
			end
			ST_F_NXT: begin
				ram_req.addr = ADDR_W'(nxt_cur);
				state_d = (nxt_cur < POS_W'(pool_limit_q)) ? ST_F_NCHK : ST_RESP;
			end
			ST_F_NCHK: begin
				if (hfree) begin
					ram_req.we    = 1'b1;
					ram_req.wdata = {1'b1, merge_next};
				end
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			pool_active_q <= 1'b0;
			pool_limit_q  <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				if (s_type == REQ_INIT && init_ok) begin
					pool_active_q <= 1'b1;
					pool_limit_q  <= s_size;
				end
				if (s_type == REQ_DONE) begin
					pool_active_q <= 1'b0;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tvalid && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					req_type_q  <= s_type;
					req_size_q  <= s_size;
					req_offs_q  <= s_offs;
					res_offs_q  <= '0;
					pos_q       <= '0;
					have_prev_q <= 1'b0;
					unique case (s_type)
						REQ_INIT: res_fail_q <= !init_ok;
						REQ_DONE: res_fail_q <= 1'b0;
						default:  res_fail_q <= 1'b1;
					endcase
				end
			end
			ST_A_CHK: begin
				if (fit) begin
					res_fail_q <= 1'b0;
					res_offs_q <= OFFS_W'(payload);
				end else begin
					pos_q <= nxt_blk;
				end
			end
			ST_F_CHK: begin
				priority if (target > payload) begin
					prev_q      <= pos_q;
					prev_size_q <= bsize;
					prev_free_q <= hfree;
					have_prev_q <= 1'b1;
					pos_q       <= nxt_blk;
				end else if (target == payload && !hfree) begin
					cur_size_q <= bsize;
					res_fail_q <= 1'b0;
				end else begin
					res_fail_q <= 1'b1;
				end
			end
			ST_F_PREV: begin
				pos_q      <= prev_q;
				cur_size_q <= merge_prev;
			end
			ST_RESP: begin
				if (out_load) begin
					out_status_q <= res_fail_q;
					out_offs_q   <= (req_type_q == REQ_ALLOC) ? res_offs_q : '0;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

// File: src/ffa_checker.sv
// Port-level assertions for the first-fit block allocator, bound to the top level.
`default_nettype none
module ffa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [31:0] s_axis_tdata,
	input logic [1:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic [0:0]  m_axis_tuser
);

	logic in_acc;
	assign in_acc = s_axis_tvalid && s_axis_tready && (s_axis_tdata[31] || !s_axis_tdata[31])
		&& (s_axis_tuser[0] || !s_axis_tuser[0]);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result transaction changed");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[11:0] == 12'd0)
		else $error("failed result carries a nonzero offset");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_axis_tready)
		else $error("ready right after an accepted transaction");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tready))
		else $error("result appeared without a request in progress");

endmodule

bind first_fit_block_allocator ffa_checker u_ffa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tdata (s_axis_tdata),
	.s_axis_tuser (s_axis_tuser),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);
`default_nettype wire

// File: verif/first_fit_block_allocator_test.sv
// Self-checking testbench for the first-fit block allocator: directed and random request streams.
`timescale 1ns / 1ps
module first_fit_block_allocator_test;
	import ffa_pkg::*;

	localparam int POOL_BYTES   = 4096;
	localparam int HEADER_BYTES = 16;
	localparam int RANDOM_ITEMS = 1400;
	localparam int HOLD_CYCLES  = 250;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic              status;
		logic [OFFS_W-1:0] alloc_offset;
	} alloc_reply_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;

	// shadow of the allocator state
	logic [HDR_W-1:0] hdr_mem [0:POOL_BYTES-1];
	bit               pool_on;
	int unsigned      pool_end;

	alloc_reply_t replies_due[$];
	int unsigned  live_offs[$];
	int unsigned  last_freed;
	int           burst_left;
	bit           hold_req;
	int           error_count;
	int           n_items, n_init_ok, n_alloc_ok, n_free_ok, n_done, n_refused;

	first_fit_block_allocator #(
		.POOL_BYTES(POOL_BYTES),
		.HEADER_BYTES(HEADER_BYTES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#60_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic int unsigned hdr_size(int unsigned pos);
		return (pos < POOL_BYTES) ? int'(hdr_mem[pos][SIZE_W-1:0]) : 0;
	endfunction

	function automatic bit hdr_is_free(int unsigned pos);
		return (pos < POOL_BYTES) && (hdr_mem[pos][FREE_BIT] == 1'b1);
	endfunction

	function automatic void hdr_put(int unsigned pos, int unsigned size, bit is_free);
		logic [SIZE_W-1:0] sz;
		sz = size[SIZE_W-1:0];
		if (pos < POOL_BYTES)
			hdr_mem[pos] = {is_free, sz};
	endfunction

	function automatic bit pool_init(int unsigned size);
		if (pool_on || size < HEADER_BYTES || size > POOL_BYTES)
			return 1'b0;
		pool_end = size;
		hdr_put(0, size - HEADER_BYTES, 1'b1);
		pool_on = 1'b1;
		return 1'b1;
	endfunction

	function automatic bit first_fit(int unsigned size, output int unsigned offset);
		int unsigned pos, bsize;
		bit          taken;
		pos    = 0;
		taken  = 1'b0;
		offset = 0;
		if (!pool_on || size == 0)
			return 1'b0;
		while (!taken && pos < pool_end && pos < POOL_BYTES) begin
			bsize = hdr_size(pos);
			if (hdr_is_free(pos) && bsize >= size) begin
				if (bsize - size > HEADER_BYTES) begin
					hdr_put(pos + HEADER_BYTES + size, bsize - size - HEADER_BYTES, 1'b1);
					bsize = size;
				end
				hdr_put(pos, bsize, 1'b0);
				offset = pos + HEADER_BYTES;
				taken  = 1'b1;
			end else begin
				pos = pos + HEADER_BYTES + bsize;
			end
		end
		return taken;
	endfunction

	function automatic bit release_block(int unsigned target);
		int unsigned pos, prev, nxt, payload;
		bit          have_prev, found;
		pos       = 0;
		prev      = 0;
		have_prev = 1'b0;
		found     = 1'b0;
		if (!pool_on)
			return 1'b0;
		while (!found && pos < pool_end && pos < POOL_BYTES) begin
			payload = pos + HEADER_BYTES;
			if (target > payload) begin
				prev      = pos;
				have_prev = 1'b1;
				pos       = pos + HEADER_BYTES + hdr_size(pos);
			end else if (target == payload) begin
				found = 1'b1;
			end else begin
				return 1'b0;
			end
		end
		if (!found || hdr_is_free(pos))
			return 1'b0;
		hdr_put(pos, hdr_size(pos), 1'b1);
		if (have_prev && hdr_is_free(prev)) begin
			hdr_put(prev, hdr_size(prev) + HEADER_BYTES + hdr_size(pos), 1'b1);
			pos = prev;
		end
		nxt = pos + HEADER_BYTES + hdr_size(pos);
		if (nxt < pool_end && hdr_is_free(nxt))
			hdr_put(pos, hdr_size(pos) + HEADER_BYTES + hdr_size(nxt), 1'b1);
		return 1'b1;
	endfunction

	function automatic alloc_reply_t allocator_reply(logic [1:0] kind, logic [SIZE_W-1:0] size,
			logic [OFFS_W-1:0] offs);
		alloc_reply_t r;
		bit           ok;
		int unsigned  where;
		where = 0;
		case (kind)
			REQ_INIT:  ok = pool_init(int'(size));
			REQ_ALLOC: ok = first_fit(int'(size), where);
			REQ_FREE:  ok = release_block(int'(offs));
			default: begin
				pool_on = 1'b0;
				ok      = 1'b1;
			end
		endcase
		if (!ok)
			where = 0;
		r.status       = ~ok;
		r.alloc_offset = where[OFFS_W-1:0];
		return r;
	endfunction

	task automatic send_req(input logic [1:0] kind, input int unsigned size,
			input int unsigned offs);
		alloc_reply_t r;
		int           idx;
		logic [SIZE_W-1:0] sz;
		logic [OFFS_W-1:0] of;
		sz = size[SIZE_W-1:0];
		of = offs[OFFS_W-1:0];
		if (burst_left <= 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) :
				$urandom_range(1, 12);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, of, sz};
		s_axis_tuser  <= kind;
		do @(posedge clk); while (!s_axis_tready);
		burst_left--;
		r = allocator_reply(kind, sz, of);
		replies_due.push_back(r);
		n_items++;
		if (r.status)
			n_refused++;
		case (kind)
			REQ_INIT: begin
				if (!r.status) begin
					n_init_ok++;
					live_offs.delete();
				end
			end
			REQ_ALLOC: begin
				if (!r.status) begin
					n_alloc_ok++;
					live_offs.push_back(int'(r.alloc_offset));
				end
			end
			REQ_FREE: begin
				if (!r.status) begin
					n_free_ok++;
					last_freed = of;
					for (idx = live_offs.size() - 1; idx >= 0; idx--)
						if (live_offs[idx] == of)
							live_offs.delete(idx);
				end
			end
			default: begin
				n_done++;
				live_offs.delete();
			end
		endcase
	endtask

	// receiver: ready pattern with changing modes, plus an occasional long hold
	initial begin
		int mode, mode_left, phase;
		mode      = 0;
		mode_left = 0;
		phase     = 0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 300);
			end
			mode_left--;
			phase++;
			case (mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= $urandom_range(0, 1);
				2: m_axis_tready <= ($urandom_range(0, 3) == 0);
				default: m_axis_tready <= (phase % 3 == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		alloc_reply_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (replies_due.size() == 0) begin
				$error("unexpected transaction: status %0d alloc_offset %0d",
					m_axis_tuser[0], m_axis_tdata[OFFS_W-1:0]);
				error_count++;
			end else begin
				want = replies_due.pop_front();
				if (m_axis_tuser[0] !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, m_axis_tuser[0]);
					error_count++;
				end
				if (m_axis_tdata[OFFS_W-1:0] !== want.alloc_offset) begin
					$error("alloc_offset: expected %0d, actual %0d", want.alloc_offset,
						m_axis_tdata[OFFS_W-1:0]);
					error_count++;
				end
			end
		end
	end

	task automatic test_idle_pool;
		send_req(REQ_ALLOC, 1, 0);
		send_req(REQ_FREE, 0, 16);
		send_req(REQ_DONE, 0, 0);
	endtask

	task automatic test_init_limits;
		send_req(REQ_INIT, HEADER_BYTES - 1, 0);
		send_req(REQ_INIT, HEADER_BYTES, 0);
		send_req(REQ_ALLOC, 1, 0);
		send_req(REQ_FREE, 0, HEADER_BYTES);
		send_req(REQ_INIT, 32, 0);
		send_req(REQ_DONE, 0, 0);
		send_req(REQ_DONE, 0, 0);
	endtask

	task automatic test_full_pool;
		send_req(REQ_INIT, POOL_BYTES, 0);
		send_req(REQ_ALLOC, POOL_BYTES, 0);
		send_req(REQ_ALLOC, POOL_BYTES - HEADER_BYTES, 0);
		send_req(REQ_FREE, 0, HEADER_BYTES + 1);
		send_req(REQ_FREE, 0, HEADER_BYTES);
		send_req(REQ_FREE, 0, HEADER_BYTES);
		send_req(REQ_ALLOC, POOL_BYTES - 2 * HEADER_BYTES, 0);
		send_req(REQ_FREE, 0, POOL_BYTES - 1);
		send_req(REQ_DONE, 0, 0);
	endtask

	task automatic test_split_merge;
		send_req(REQ_INIT, 1024, 0);
		send_req(REQ_ALLOC, 100, 0);
		send_req(REQ_ALLOC, 200, 0);
		send_req(REQ_ALLOC, 300, 0);
		send_req(REQ_FREE, 0, 132);
		send_req(REQ_FREE, 0, 16);
		send_req(REQ_FREE, 0, 348);
		send_req(REQ_ALLOC, 1024 - HEADER_BYTES, 0);
	endtask

	task automatic test_output_stall;
		int k;
		hold_req   = 1'b1;
		burst_left = 40;
		send_req(REQ_DONE, 0, 0);
		send_req(REQ_INIT, 1024, 0);
		for (k = 0; k < 10; k++)
			send_req(REQ_ALLOC, $urandom_range(1, 32), $urandom_range(0, 4095));
		for (k = 0; k < 4 && live_offs.size() > 0; k++)
			send_req(REQ_FREE, $urandom_range(0, 4096), live_offs[0]);
	endtask

	task automatic test_random_sessions;
		int          ops, k, pick, sel;
		int unsigned psize, asize;
		while (n_items < RANDOM_ITEMS) begin
			send_req(REQ_DONE, $urandom_range(0, 4096), $urandom_range(0, 4095));
			pick = $urandom_range(0, 99);
			if (pick < 75)
				psize = $urandom_range(64, 768);
			else if (pick < 85)
				psize = $urandom_range(HEADER_BYTES, 63);
			else if (pick < 95)
				psize = $urandom_range(769, POOL_BYTES);
			else if (pick < 97)
				psize = POOL_BYTES;
			else
				psize = $urandom_range(0, HEADER_BYTES - 1);
			send_req(REQ_INIT, psize, $urandom_range(0, 4095));
			ops = $urandom_range(20, 80);
			for (k = 0; k < ops; k++) begin
				pick = $urandom_range(0, 99);
				sel  = $urandom_range(0, 99);
				if (pick < 50 || (pick < 88 && live_offs.size() == 0)) begin
					if (sel < 85)
						asize = $urandom_range(1, 96);
					else if (sel < 95)
						asize = $urandom_range(97, 1024);
					else if (sel < 98)
						asize = 0;
					else
						asize = $urandom_range(1025, 4096);
					send_req(REQ_ALLOC, asize, $urandom_range(0, 4095));
				end else if (pick < 88) begin
					send_req(REQ_FREE, $urandom_range(0, 4096),
						live_offs[$urandom_range(0, live_offs.size() - 1)]);
				end else if (pick < 95) begin
					if (sel < 50)
						send_req(REQ_FREE, $urandom_range(0, 4096), last_freed);
					else
						send_req(REQ_FREE, $urandom_range(0, 4096), $urandom_range(0, 4095));
				end else if (pick < 97) begin
					send_req(REQ_INIT, $urandom_range(0, 4096), $urandom_range(0, 4095));
				end else begin
					send_req(REQ_DONE, $urandom_range(0, 4096), $urandom_range(0, 4095));
				end
			end
		end
	endtask

	initial begin
		foreach (hdr_mem[i])
			hdr_mem[i] = '0;
		pool_on     = 1'b0;
		pool_end    = 0;
		last_freed  = 0;
		burst_left  = 0;
		hold_req    = 1'b0;
		error_count = 0;
		n_items     = 0;
		n_init_ok   = 0;
		n_alloc_ok  = 0;
		n_free_ok   = 0;
		n_done      = 0;
		n_refused   = 0;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= REQ_INIT;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_pool();
		test_init_limits();
		test_full_pool();
		test_split_merge();
		test_output_stall();
		test_random_sessions();
		test_output_stall();

		s_axis_tvalid <= 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d requests: %0d inits, %0d allocations, %0d frees, %0d done",
			n_items, n_init_ok, n_alloc_ok, n_free_ok, n_done);
		$display("Refused requests (no fit, misses, double frees, bad inits): %0d", n_refused);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: sim.f
src/ffa_pkg.sv
src/ffa_hdr_ram.sv
src/first_fit_block_allocator.sv
src/ffa_checker.sv
verif/first_fit_block_allocator_test.sv
